// File: hw/rtl/pitch_comb_filter_defines.svh
// Assertion macros shared by the pitch comb filter RTL.
`ifndef PITCH_COMB_FILTER_DEFINES_SVH
`define PITCH_COMB_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCF_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("pitch comb filter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("pitch comb filter assertion failed");

`endif

// File: hw/rtl/pcf_pkg.sv
// Types and constants shared by the pitch comb filter modules.
package pcf_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int LAG_W         = 9;
  localparam int WEIGHT_W      = 15;
  localparam int CFG_LAG_W     = 8;
  localparam int APB_DATA_W    = 32;
  localparam int SAMPLE_MAX    = 32767;
  localparam int Q15_SHIFT     = 15;
  localparam int LAG_FLOOR_RST = 31;
  localparam int LAG_CEIL_RST  = 201;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [LAG_W-1:0]           pitch_lag;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       bypassed;
  } out_word_t;

  typedef struct packed {
    logic [CFG_LAG_W-1:0] lag_floor;
    logic [CFG_LAG_W-1:0] lag_ceiling;
  } lag_cfg_t;

  // Normalized Hann window for the first five taps, zero beyond.
  function automatic logic [WEIGHT_W-1:0] hann_reset(int k);
    logic [WEIGHT_W-1:0] w;
    case (k)
      0, 4:    w = WEIGHT_W'(2731);
      1, 3:    w = WEIGHT_W'(8192);
      2:       w = WEIGHT_W'(10923);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/pcf_ram.sv
// Generic RAM: one write port, two registered read ports.
module pcf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// File: hw/rtl/pcf_cfg_regs.sv
// APB register file: tap weights and lag window.
module pcf_cfg_regs #(
  parameter int TAPS = 5,
  parameter int PaddrW = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [PaddrW-1:0]                 paddr_i,
  input  logic [pcf_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [pcf_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic [pcf_pkg::WEIGHT_W-1:0]      weight_o [TAPS],
  output pcf_pkg::lag_cfg_t                 lag_cfg_o
);

  import pcf_pkg::*;

  localparam int IdxW          = PaddrW - 2;
  localparam int RegLagFloor   = TAPS;
  localparam int RegLagCeiling = TAPS + 1;

  logic [IdxW-1:0]     idx;
  logic                wr_en;
  logic [WEIGHT_W-1:0] weight_q [TAPS];
  logic [WEIGHT_W-1:0] weight_d [TAPS];
  lag_cfg_t            lag_q;
  lag_cfg_t            lag_d;

  assign idx   = paddr_i[PaddrW-1:2];
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    weight_d = weight_q;
    lag_d    = lag_q;
    if (wr_en) begin
      for (int k = 0; k < TAPS; k++) begin
        if (idx == IdxW'(k)) begin
          weight_d[k] = pwdata_i[WEIGHT_W-1:0];
        end
      end
      if (idx == IdxW'(RegLagFloor)) begin
        lag_d.lag_floor = pwdata_i[CFG_LAG_W-1:0];
      end
      if (idx == IdxW'(RegLagCeiling)) begin
        lag_d.lag_ceiling = pwdata_i[CFG_LAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        weight_q[k] <= hann_reset(k);
      end
      lag_q.lag_floor   <= CFG_LAG_W'(LAG_FLOOR_RST);
      lag_q.lag_ceiling <= CFG_LAG_W'(LAG_CEIL_RST);
    end else begin
      weight_q <= weight_d;
      lag_q    <= lag_d;
    end
  end

  always_comb begin
    prdata_o = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (idx == IdxW'(k)) begin
        prdata_o = {{(APB_DATA_W-WEIGHT_W){1'b0}}, weight_q[k]};
      end
    end
    if (idx == IdxW'(RegLagFloor)) begin
      prdata_o = {{(APB_DATA_W-CFG_LAG_W){1'b0}}, lag_q.lag_floor};
    end
    if (idx == IdxW'(RegLagCeiling)) begin
      prdata_o = {{(APB_DATA_W-CFG_LAG_W){1'b0}}, lag_q.lag_ceiling};
    end
  end

  assign weight_o  = weight_q;
  assign lag_cfg_o = lag_q;

endmodule

// File: hw/rtl/pcf_accum.sv
// Multiply, sum, truncate and clip stages of the comb filter.
`include "pitch_comb_filter_defines.svh"

module pcf_accum #(
  parameter int TAPS = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pcf_pkg::SAMPLE_W-1:0] tap_val_i [TAPS],
  input  logic [pcf_pkg::WEIGHT_W-1:0]        weight_i [TAPS],
  input  logic                                bypass_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcf_pkg::out_word_t                  out_word_o
);

  import pcf_pkg::*;

  localparam int HALF  = TAPS / 2;
  localparam int ProdW = 2 * SAMPLE_W;
  localparam int AccW  = ProdW + $clog2(TAPS);

  logic                       en4, en5, en6;
  logic                       v4_q, v5_q, out_valid_q;
  logic signed [ProdW-1:0]    prod_q [TAPS];
  logic signed [ProdW-1:0]    prod_d [TAPS];
  logic signed [SAMPLE_W-1:0] centre4_q, centre5_q;
  logic                       byp4_q, byp5_q;
  logic signed [AccW-1:0]     sum_d, sum_q;
  logic signed [AccW-1:0]     bias, quo;
  logic signed [SAMPLE_W-1:0] filt_d;
  out_word_t                  out_q;

  assign en6        = !out_valid_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_d[k] = $signed({1'b0, weight_i[k]}) * tap_val_i[k];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum_d = sum_d + AccW'(prod_q[k]);
    end
  end

  // Truncate toward zero, then clip to the symmetric sample range; in bypass the centre sample is clipped alike.
  always_comb begin
    bias = sum_q[AccW-1] ? AccW'((1 << Q15_SHIFT) - 1) : '0;
    quo  = (sum_q + bias) >>> Q15_SHIFT;
    if (byp5_q) begin
      filt_d = (centre5_q < -SAMPLE_W'(SAMPLE_MAX)) ? -SAMPLE_W'(SAMPLE_MAX) : centre5_q;
    end else if (quo > AccW'(SAMPLE_MAX)) begin
      filt_d = SAMPLE_W'(SAMPLE_MAX);
    end else if (quo < -AccW'(SAMPLE_MAX)) begin
      filt_d = -SAMPLE_W'(SAMPLE_MAX);
    end else begin
      filt_d = quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      prod_q    <= prod_d;
      centre4_q <= tap_val_i[HALF];
      byp4_q    <= bypass_i;
    end
    if (en5 && v4_q) begin
      sum_q     <= sum_d;
      centre5_q <= centre4_q;
      byp5_q    <= byp4_q;
    end
    if (en6 && v5_q) begin
      out_q.filtered_sample <= filt_d;
      out_q.bypassed        <= byp5_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `PCF_ASSERT_IMPL(a_no_min_sample, clk_i, rst_ni, out_valid_q, out_q.filtered_sample != SAMPLE_W'(-SAMPLE_MAX - 1))
  `PCF_ASSERT_IMPL(a_stalled_means_full, clk_i, rst_ni, !in_ready_o, v4_q && v5_q && out_valid_q)
  `PCF_ASSERT_NEXT(a_bypass_reaches_out, clk_i, rst_ni, v5_q && byp5_q && en6, out_q.bypassed)

endmodule

// File: hw/rtl/pitch_comb_filter.sv
// Top level of the pitch comb filter: history ring, tap addressing and pipeline control.
//
// The filter takes one word per clock while the output side does not stall
// and returns one word for each word that it has taken. Throughput is
// set by the single write port of the history RAMs, which every word uses once;
// the TAPS history reads of a word are spread over (TAPS+1)/2 copies of the
// ring, each with two read ports, all written alike. The stages are: input
// capture, tap position arithmetic, ring reduction and RAM access, Q15 products,
// tap sum, and truncate/clip into the output register. A wrap flag marks when
// the ring has been fully written; until then slots not yet written read as
// zero, so there is no clearing pass after reset. Registers sit on an APB port
// and must be written while no word is in flight.
`include "pitch_comb_filter_defines.svh"

module pitch_comb_filter #(
  parameter int TAPS = 5,
  parameter int HISTORY_DEPTH = 1024,
  parameter int FRAME_LEN = 160,
  localparam int PaddrW = $clog2(4 * (TAPS + 2))
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcf_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcf_pkg::out_word_t             out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PaddrW-1:0]              paddr,
  input  logic [pcf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import pcf_pkg::*;

  localparam int HALF        = TAPS / 2;
  localparam int AW          = $clog2(HISTORY_DEPTH);
  localparam int NRAM        = (TAPS + 1) / 2;
  localparam int CentreDelay = 3 * FRAME_LEN;
  localparam int CdMod       = CentreDelay % HISTORY_DEPTH;
  localparam int LagMax      = (1 << LAG_W) - 1;
  localparam int NK          = (HALF * LagMax + CdMod + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int PosBase     = NK * HISTORY_DEPTH - CdMod;
  localparam int RedSteps    = $clog2(2 * NK + 2);
  localparam int PosW        = AW + RedSteps;

  // Bring a biased tap position back into the ring, one binary step at a time.
  function automatic logic [AW-1:0] ring_reduce(logic [PosW-1:0] pos);
    logic [PosW-1:0] v;
    v = pos;
    for (int j = RedSteps - 1; j >= 0; j--) begin
      if (v >= (PosW'(HISTORY_DEPTH) << j)) begin
        v = v - (PosW'(HISTORY_DEPTH) << j);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [WEIGHT_W-1:0] weight [TAPS];
  lag_cfg_t            lag_cfg;

  logic en1, en2, en3, acc_ready, ram_en;
  logic v1_q, v2_q, v3_q;

  logic [AW-1:0] wp_q, wp_d;
  logic          wrapped_q, wrapped_d;
  logic          in_range;

  logic signed [SAMPLE_W-1:0] s1_sample_q, s2_sample_q, s3_sample_q;
  logic [LAG_W-1:0]           s1_lag_q;
  logic [AW-1:0]              s1_wp_q, s2_wp_q;
  logic                       s1_wrapped_q, s2_wrapped_q;
  logic                       s1_byp_q, s2_byp_q, s3_byp_q;

  logic [PosW-1:0] pos_d [TAPS];
  logic [PosW-1:0] s2_pos_q [TAPS];
  logic [AW-1:0]   idx [TAPS];
  logic [TAPS-1:0] fwd_d, live_d, s3_fwd_q, s3_live_q;

  logic [AW-1:0]              ram_raddr [2*NRAM];
  logic [SAMPLE_W-1:0]        ram_rdata [2*NRAM];
  logic signed [SAMPLE_W-1:0] tap_val [TAPS];

  pcf_cfg_regs #(
    .TAPS   (TAPS),
    .PaddrW (PaddrW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .weight_o  (weight),
    .lag_cfg_o (lag_cfg)
  );

  assign pready = 1'b1;

  // Stall chain: a stage moves when it is empty or the next one moves.
  assign en3        = !v3_q || acc_ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign in_range = (in_word_i.pitch_lag > LAG_W'(lag_cfg.lag_floor)) &&
                    (in_word_i.pitch_lag < LAG_W'(lag_cfg.lag_ceiling));

  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (in_valid_i && en1) begin
      if (wp_q == AW'(HISTORY_DEPTH - 1)) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Biased so the position never goes negative before reduction.
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      pos_d[k] = PosW'(s1_wp_q) + PosW'(PosBase) - PosW'(HALF * int'(s1_lag_q))
               + PosW'(k * int'(s1_lag_q));
    end
  end

  // A tap on this word's own slot takes the incoming sample; slots never
  // written read as zero.
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      idx[k]    = ring_reduce(s2_pos_q[k]);
      fwd_d[k]  = (idx[k] == s2_wp_q);
      live_d[k] = s2_wrapped_q || (idx[k] < s2_wp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_sample_q  <= in_word_i.sample_in;
      s1_lag_q     <= in_word_i.pitch_lag;
      s1_wp_q      <= wp_q;
      s1_wrapped_q <= wrapped_q;
      s1_byp_q     <= !in_range;
    end
    if (en2 && v1_q) begin
      s2_pos_q     <= pos_d;
      s2_sample_q  <= s1_sample_q;
      s2_wp_q      <= s1_wp_q;
      s2_wrapped_q <= s1_wrapped_q;
      s2_byp_q     <= s1_byp_q;
    end
    if (ram_en) begin
      s3_fwd_q    <= fwd_d;
      s3_live_q   <= live_d;
      s3_sample_q <= s2_sample_q;
      s3_byp_q    <= s2_byp_q;
    end
  end

  // Write and read the ring at the same edge, in word order.
  assign ram_en = v2_q && en3;

  always_comb begin
    for (int k = 0; k < 2 * NRAM; k++) begin
      ram_raddr[k] = '0;
    end
    for (int k = 0; k < TAPS; k++) begin
      ram_raddr[k] = idx[k];
    end
  end

  for (genvar r = 0; r < NRAM; r++) begin : g_ring
    pcf_ram #(
      .Width (SAMPLE_W),
      .Depth (HISTORY_DEPTH)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (ram_en),
      .waddr_i  (s2_wp_q),
      .wdata_i  (s2_sample_q),
      .re_i     (ram_en),
      .raddr0_i (ram_raddr[2*r]),
      .raddr1_i (ram_raddr[2*r+1]),
      .rdata0_o (ram_rdata[2*r]),
      .rdata1_o (ram_rdata[2*r+1])
    );
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      if (s3_fwd_q[k]) begin
        tap_val[k] = s3_sample_q;
      end else if (s3_live_q[k]) begin
        tap_val[k] = $signed(ram_rdata[k]);
      end else begin
        tap_val[k] = '0;
      end
    end
  end

  pcf_accum #(
    .TAPS (TAPS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (acc_ready),
    .tap_val_i   (tap_val),
    .weight_i    (weight),
    .bypass_i    (s3_byp_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `PCF_ASSERT_NEXT(a_wrap_sticky, clk_i, rst_ni, wrapped_q, wrapped_q)
  `PCF_ASSERT_IMPL(a_stalled_means_full, clk_i, rst_ni, !in_ready_o, v1_q && v2_q && v3_q)
  `PCF_ASSERT_NEXT(a_stage3_hold, clk_i, rst_ni, v3_q && !acc_ready, v3_q && $stable(s3_sample_q))

endmodule

// File: tb/pitch_comb_filter_checker.sv
// Checker for the pitch comb filter: tracks registers, predicts each output word, compares.
module pitch_comb_filter_checker #(
  parameter int TAPS = 5,
  parameter int HISTORY_DEPTH = 1024,
  parameter int FRAME_LEN = 160,
  localparam int PaddrW = $clog2(4 * (TAPS + 2))
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  pcf_pkg::in_word_t              in_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  pcf_pkg::out_word_t             out_word_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [PaddrW-1:0]              paddr_i,
  input  logic [pcf_pkg::APB_DATA_W-1:0] pwdata_i,
  input  logic                           pready_i,
  output int                             mismatch_count_o,
  output int                             words_in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  localparam int CentreDelay     = 3 * FRAME_LEN;
  localparam int SlotMask        = HISTORY_DEPTH - 1;
  localparam int FullScale       = 32767;
  localparam int Q15One          = 32768;
  localparam int LagFloorReset   = 31;
  localparam int LagCeilingReset = 201;
  localparam int PrintCap        = 100;

  logic signed [SAMPLE_W-1:0]       sample_ring [HISTORY_DEPTH];
  logic [$clog2(HISTORY_DEPTH)-1:0] write_slot;
  logic [WEIGHT_W-1:0]              tap_weight [TAPS];
  logic [CFG_LAG_W-1:0]             lag_floor;
  logic [CFG_LAG_W-1:0]             lag_ceiling;
  out_word_t                        pending_filtered [$];
  int                               mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic report_mismatch(string what);
    if (mismatch_count < PrintCap) begin
      $display("%0t ns: filter output mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Store the new sample first, then sum the taps around the centre sample or pass it alone.
  function automatic out_word_t filter_next_sample(in_word_t w);
    longint    acc;
    int        centre_pos;
    int        lag;
    int        k;
    out_word_t r;
    sample_ring[write_slot] = w.sample_in;
    centre_pos = int'(write_slot) - CentreDelay;
    lag = int'(w.pitch_lag);
    if (lag > int'(lag_floor) && lag < int'(lag_ceiling)) begin
      acc = 0;
      for (k = 0; k < TAPS; k++) begin
        acc += longint'(tap_weight[k]) *
               longint'(sample_ring[(centre_pos + (k - TAPS / 2) * lag) & SlotMask]);
      end
      acc = acc / Q15One;
      r.bypassed = 1'b0;
    end else begin
      acc = longint'(sample_ring[centre_pos & SlotMask]);
      r.bypassed = 1'b1;
    end
    if (acc > FullScale) begin
      acc = FullScale;
    end else if (acc < -FullScale) begin
      acc = -FullScale;
    end
    r.filtered_sample = acc[SAMPLE_W-1:0];
    write_slot = write_slot + 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_words
    out_word_t expected_word;
    int        reg_index;
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        sample_ring[i] = '0;
      end
      for (int i = 0; i < TAPS; i++) begin
        case (i)
          0, 4:    tap_weight[i] = WEIGHT_W'(2731);
          1, 3:    tap_weight[i] = WEIGHT_W'(8192);
          2:       tap_weight[i] = WEIGHT_W'(10923);
          default: tap_weight[i] = '0;
        endcase
      end
      write_slot = '0;
      lag_floor = CFG_LAG_W'(LagFloorReset);
      lag_ceiling = CFG_LAG_W'(LagCeilingReset);
      pending_filtered.delete();
      words_in_flight_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        reg_index = int'(paddr_i) / 4;
        // keep only the register's width; drop writes past the last register
        if (reg_index < TAPS) begin
          tap_weight[reg_index] = pwdata_i[WEIGHT_W-1:0];
        end else if (reg_index == TAPS) begin
          lag_floor = pwdata_i[CFG_LAG_W-1:0];
        end else if (reg_index == TAPS + 1) begin
          lag_ceiling = pwdata_i[CFG_LAG_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_filtered.size() == 0) begin
          report_mismatch("output word with no input word waiting");
        end else begin
          expected_word = pending_filtered.pop_front();
          if (out_word_i.filtered_sample !== expected_word.filtered_sample) begin
            report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                                      out_word_i.filtered_sample,
                                      expected_word.filtered_sample));
          end
          if (out_word_i.bypassed !== expected_word.bypassed) begin
            report_mismatch($sformatf("bypassed %b, expected %b",
                                      out_word_i.bypassed, expected_word.bypassed));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_filtered.push_back(filter_next_sample(in_word_i));
      end
      words_in_flight_o <= pending_filtered.size();
    end
  end

endmodule

// File: tb/tb_pitch_comb_filter.sv
// Testbench top for the pitch comb filter: clock, reset, stimulus and verdict.
module tb_pitch_comb_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  localparam int Taps          = 5;
  localparam int HistoryDepth  = 1024;
  localparam int FrameLen      = 160;
  localparam int PaddrW        = $clog2(4 * (Taps + 2));
  localparam int ClkPeriod     = 10;
  localparam int RegTap0       = 0;
  localparam int RegLagFloor   = Taps;
  localparam int RegLagCeiling = Taps + 1;
  localparam int RegSpare      = Taps + 2;
  localparam int IdlePct       = 11;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 16;
  localparam int PhaseWords    = 150;
  localparam int CycleLimit    = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PaddrW-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    mismatch_count;
  int                    words_in_flight;
  int                    cycle_count = 0;
  int                    tx_idle_pct = IdlePct;
  int                    rx_idle_pct = IdlePct;
  logic                  hold_req = 1'b0;
  logic [31:0]           weight_cfg [Taps];
  logic [CFG_LAG_W-1:0]  cfg_floor = 8'd31;
  logic [CFG_LAG_W-1:0]  cfg_ceiling = 8'd201;

  always #(ClkPeriod / 2) clk = ~clk;

  pitch_comb_filter #(
    .TAPS(Taps),
    .HISTORY_DEPTH(HistoryDepth),
    .FRAME_LEN(FrameLen)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o(out_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  pitch_comb_filter_checker #(
    .TAPS(Taps),
    .HISTORY_DEPTH(HistoryDepth),
    .FRAME_LEN(FrameLen)
  ) u_filter_check (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_i(in_ready),
    .in_word_i(in_word),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_word_i(out_word),
    .psel_i(psel),
    .penable_i(penable),
    .pwrite_i(pwrite),
    .paddr_i(paddr),
    .pwdata_i(pwdata),
    .pready_i(pready),
    .mismatch_count_o(mismatch_count),
    .words_in_flight_o(words_in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off counted here.
  initial begin : drive_out_ready
    int   hold_left;
    logic hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic apb_write(int index, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PaddrW'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and hold until every word sent has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_filter_config(logic [31:0] floor_word, logic [31:0] ceiling_word);
    wait_drained();
    for (int k = 0; k < Taps; k++) begin
      apb_write(RegTap0 + k, weight_cfg[k]);
    end
    apb_write(RegLagFloor, floor_word);
    apb_write(RegLagCeiling, ceiling_word);
    cfg_floor = floor_word[CFG_LAG_W-1:0];
    cfg_ceiling = ceiling_word[CFG_LAG_W-1:0];
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic [LAG_W-1:0] lag);
    in_word_t w;
    w.sample_in = sample;
    w.pitch_lag = lag;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return 16'h8000;
    end else if (r < 16) begin
      return 16'h7FFF;
    end else if (r < 20) begin
      return SAMPLE_W'(int'($urandom_range(8)) - 4);
    end
    return SAMPLE_W'($urandom);
  endfunction

  // Mostly lags inside the filtering range, some on its edges, some anywhere.
  function automatic logic [LAG_W-1:0] pick_lag();
    int r;
    int lo;
    int hi;
    r = $urandom_range(99);
    lo = int'(cfg_floor) + 1;
    hi = int'(cfg_ceiling) - 1;
    if (r < 75 && hi >= lo) begin
      return LAG_W'($urandom_range(hi, lo));
    end else if (r < 85) begin
      return $urandom_range(1) ? LAG_W'(cfg_floor) : LAG_W'(cfg_ceiling);
    end
    return LAG_W'($urandom_range(511, 0));
  endfunction

  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 32'd0;
    end else if (r == 1) begin
      return 32'd32767;
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    int floor_val;
    int ceiling_val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes of both fields and both lag boundaries
    send_sample(16'h0000, 9'd0);
    send_sample(16'h8000, 9'd511);
    send_sample(16'h7FFF, 9'd256);
    send_sample(16'hFFFF, 9'd31);
    send_sample(16'h0001, 9'd32);
    send_sample(16'h5555, 9'd200);
    send_sample(16'hAAAA, 9'd201);
    send_sample(16'h8000, 9'd100);
    send_sample(16'h7FFF, 9'd1);
    send_sample(16'h3039, 9'd255);

    // widest range: a lag of 240 puts the last tap on the newest sample
    weight_cfg = '{32'd2731, 32'd8192, 32'd10923, 32'd8192, 32'd2731};
    write_filter_config(32'd0, 32'd241);
    send_sample(16'h8000, 9'd240);
    send_sample(16'h7FFF, 9'd240);
    send_sample(16'h0064, 9'd1);
    send_sample(16'hFFFB, 9'd0);
    send_sample(16'h0007, 9'd241);
    send_sample(16'h8000, 9'd120);
    send_sample(16'h7FFF, 9'd239);
    send_sample(16'h0000, 9'd511);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          weight_cfg = '{32'd2731, 32'd8192, 32'd10923, 32'd8192, 32'd2731};
          write_filter_config(32'd31, 32'd201);
        end
        1: begin
          // full-scale weights push the sum past the sample range; run without any idling
          for (int k = 0; k < Taps; k++) weight_cfg[k] = 32'hFFFF_FFFF;
          write_filter_config(32'h0000_FF00, 32'd241);
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
        2: begin
          // empty lag range: everything passes through
          for (int k = 0; k < Taps; k++) weight_cfg[k] = 32'd0;
          write_filter_config(32'hFFFF_FF00 | 32'd240, 32'd241);
          apb_write(RegSpare, $urandom);
          tx_idle_pct = IdlePct;
          rx_idle_pct <= IdlePct;
        end
        3: begin
          for (int k = 0; k < Taps; k++) weight_cfg[k] = pick_weight();
          floor_val = $urandom_range(100, 0);
          ceiling_val = $urandom_range(241, floor_val + 2);
          write_filter_config(floor_val, ceiling_val);
          hold_req <= 1'b1;
        end
        default: begin
          for (int k = 0; k < Taps; k++) weight_cfg[k] = pick_weight();
          floor_val = $urandom_range(240, 0);
          if ($urandom_range(99) < 85) begin
            ceiling_val = $urandom_range(241, (floor_val + 2 > 241) ? 241 : floor_val + 2);
          end else begin
            ceiling_val = $urandom_range(241, 1);
          end
          write_filter_config(floor_val, ceiling_val);
        end
      endcase
      for (int n = 0; n < PhaseWords; n++) begin
        send_sample(pick_sample(), pick_lag());
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
